// ===== design/c8alu_pkg.sv =====
// Shared types and constants for the 8-bit ALU with flags.
`default_nettype none
package c8alu_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned FLAGS_W = 4;

   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_V = 2;
   localparam int unsigned FLAG_N = 3;

   typedef enum logic [3:0] {
      CMD_LOAD = 4'd0,
      CMD_CMP  = 4'd1,
      CMD_CPX  = 4'd2,
      CMD_CPY  = 4'd3,
      CMD_AND  = 4'd4,
      CMD_ORA  = 4'd5,
      CMD_EOR  = 4'd6,
      CMD_BIT  = 4'd7,
      CMD_ASL  = 4'd8,
      CMD_LSR  = 4'd9,
      CMD_ROL  = 4'd10,
      CMD_ROR  = 4'd11,
      CMD_ADC  = 4'd12,
      CMD_SBC  = 4'd13,
      CMD_DEC  = 4'd14,
      CMD_INC  = 4'd15
   } cmd_type;

   typedef logic [DATA_W-1:0] byte_type;

   typedef struct packed {
      cmd_type              command;
      byte_type             operand;
      byte_type             accumulator;
      byte_type             x_value;
      byte_type             y_value;
      logic [FLAGS_W-1:0]   flags_in;
   } req_type;

   typedef struct packed {
      byte_type result;
      logic     negative;
      logic     zero_flag;
      logic     carry_out;
      logic     overflow_out;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/cpu_8bit_alu_with_flags_core.sv =====
// 8-bit ALU with N, Z, C, V flags (6502 binary-mode rules).
// Request channel (req_*): one beat carries the command, operand, A, X, Y
// and the old flags; it is taken on a clock edge with req_valid high and
// req_stall low. Response channel (rsp_*): one beat per request, carrying
// the result byte and the new flags, taken when rsp_valid is high and
// rsp_stall low.
// A request beat passes through the input register, the ALU logic and the
// result register. Throughput: one beat per cycle while rsp_stall is low; the
// ALU is a single combinational pass between the two registers.
// When rsp_stall is held, the result register keeps its beat, the input
// register fills, and req_stall rises only once both are full; a new
// request is still taken while a finished result waits.
// Reset (synchronous, active high) empties both registers; the block holds
// no other state.
`default_nettype none
module cpu_8bit_alu_with_flags_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [3:0] req_command,
   input  wire logic [7:0] req_operand,
   input  wire logic [7:0] req_accumulator,
   input  wire logic [7:0] req_x_value,
   input  wire logic [7:0] req_y_value,
   input  wire logic [3:0] req_flags_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_result,
   output logic            rsp_negative,
   output logic            rsp_zero_flag,
   output logic            rsp_carry_out,
   output logic            rsp_overflow_out
);
   import c8alu_pkg::*;

   req_type req_beat;
   req_type op;
   rsp_type alu_res;
   rsp_type rsp_beat;
   logic    op_valid;
   logic    op_ready;

   assign req_beat.command     = cmd_type'(req_command);
   assign req_beat.operand     = req_operand;
   assign req_beat.accumulator = req_accumulator;
   assign req_beat.x_value     = req_x_value;
   assign req_beat.y_value     = req_y_value;
   assign req_beat.flags_in    = req_flags_in;

   c8alu_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_beat),
      .out_valid (op_valid),
      .out_ready (op_ready),
      .out_data  (op)
   );

   c8alu_exec u_exec (
      .op  (op),
      .res (alu_res)
   );

   c8alu_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (op_valid),
      .in_ready  (op_ready),
      .in_data   (alu_res),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_beat)
   );

   assign rsp_result       = rsp_beat.result;
   assign rsp_negative     = rsp_beat.negative;
   assign rsp_zero_flag    = rsp_beat.zero_flag;
   assign rsp_carry_out    = rsp_beat.carry_out;
   assign rsp_overflow_out = rsp_beat.overflow_out;

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (op_valid && rsp_valid && rsp_stall))
      else $error("request stalled while a register stage is free");

   a_req_beat_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> op_valid)
      else $error("accepted request beat lost from input register");

   a_op_moves_on: assert property (@(posedge clock) disable iff (reset)
      (op_valid && !rsp_stall) |=> rsp_valid)
      else $error("operation did not reach the result register");
`endif
endmodule
`default_nettype wire

// ===== design/c8alu_in_stage.sv =====
// Input register stage: captures one request beat.
`default_nettype none
module c8alu_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire c8alu_pkg::req_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output c8alu_pkg::req_type      out_data
);
   import c8alu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   assign in_stall = valid_ff & ~out_ready;
   assign take     = in_valid & ~in_stall;
   assign valid_in = take | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== design/c8alu_exec.sv =====
// Combinational ALU: result byte and N, Z, C, V for one operation.
`default_nettype none
module c8alu_exec (
   input  wire c8alu_pkg::req_type op,
   output c8alu_pkg::rsp_type      res
);
   import c8alu_pkg::*;

   byte_type         m;
   byte_type         a;
   byte_type         cmp_reg;
   logic [DATA_W:0]  cmp_diff;
   byte_type         add_b;
   logic [DATA_W:0]  add_sum;
   logic             add_v;
   logic             cin;
   logic             vin;
   byte_type         r;
   logic             n;
   logic             z;
   logic             c;
   logic             v;
   logic             nz_from_r;

   assign m   = op.operand;
   assign a   = op.accumulator;
   assign cin = op.flags_in[FLAG_C];
   assign vin = op.flags_in[FLAG_V];

   always_comb begin
      case (op.command)
         CMD_CPX: cmp_reg = op.x_value;
         CMD_CPY: cmp_reg = op.y_value;
         default: cmp_reg = a;
      endcase
   end

   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
   assign add_b    = (op.command == CMD_SBC) ? ~m : m;
   assign add_sum  = {1'b0, a} + {1'b0, add_b} + {{DATA_W{1'b0}}, cin};
   assign add_v    = ~(a[DATA_W-1] ^ add_b[DATA_W-1]) & (a[DATA_W-1] ^ add_sum[DATA_W-1]);

   always_comb begin
      r         = m;
      n         = 1'b0;
      z         = 1'b0;
      c         = cin;
      v         = vin;
      nz_from_r = 1'b1;
      case (op.command)
         CMD_LOAD: r = m;
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            n         = cmp_diff[DATA_W-1];
            z         = (cmp_reg == m);
            c         = ~cmp_diff[DATA_W];
            nz_from_r = 1'b0;
         end
         CMD_AND: r = a & m;
         CMD_ORA: r = a | m;
         CMD_EOR: r = a ^ m;
         CMD_BIT: begin
            n         = m[DATA_W-1];
            v         = m[DATA_W-2];
            z         = ((a & m) == '0);
            nz_from_r = 1'b0;
         end
         CMD_ASL: begin
            c = m[DATA_W-1];
            r = {m[DATA_W-2:0], 1'b0};
         end
         CMD_LSR: begin
            c = m[0];
            r = {1'b0, m[DATA_W-1:1]};
         end
         CMD_ROL: begin
            c = m[DATA_W-1];
            r = {m[DATA_W-2:0], cin};
         end
         CMD_ROR: begin
            c = m[0];
            r = {cin, m[DATA_W-1:1]};
         end
         CMD_ADC, CMD_SBC: begin
            r = add_sum[DATA_W-1:0];
            c = add_sum[DATA_W];
            v = add_v;
         end
         CMD_DEC: r = m - byte_type'(1);
         CMD_INC: r = m + byte_type'(1);
         default: r = m;
      endcase
      if (nz_from_r) begin
         n = r[DATA_W-1];
         z = (r == '0);
      end
   end

   assign res.result       = r;
   assign res.negative     = n;
   assign res.zero_flag    = z;
   assign res.carry_out    = c;
   assign res.overflow_out = v;
endmodule
`default_nettype wire

// ===== design/c8alu_out_stage.sv =====
// Result register stage: holds one response beat until taken.
`default_nettype none
module c8alu_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire c8alu_pkg::rsp_type in_data,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output c8alu_pkg::rsp_type      out_data
);
   import c8alu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    take;

   assign in_ready = ~valid_ff | ~out_stall;
   assign take     = in_valid & in_ready;
   assign valid_in = take | (valid_ff & out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the 8-bit ALU with flags: random and directed beats, scored per field.
module testbench;
   import c8alu_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned REPORT_MAX = 10;
   localparam int unsigned HOLD_CYCLES = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_command = '0;
   logic [7:0] req_operand = '0;
   logic [7:0] req_accumulator = '0;
   logic [7:0] req_x_value = '0;
   logic [7:0] req_y_value = '0;
   logic [3:0] req_flags_in = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_result;
   logic       rsp_negative;
   logic       rsp_zero_flag;
   logic       rsp_carry_out;
   logic       rsp_overflow_out;

   req_type     pending_beats[$];
   rsp_type     expected_results[$];
   req_type     beat_on_bus = '0;
   int unsigned beats_queued = 0;
   int unsigned results_checked = 0;
   int unsigned fail_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_run = 0;
   int unsigned quiet_cycles = 0;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;

   cpu_8bit_alu_with_flags_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_operand      (req_operand),
      .req_accumulator  (req_accumulator),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_flags_in     (req_flags_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_negative     (rsp_negative),
      .rsp_zero_flag    (rsp_zero_flag),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_overflow_out (rsp_overflow_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type alu_outcome(req_type beat);
      rsp_type    r;
      logic       cin;
      logic       nz_from_result;
      byte_type   reg_val;
      byte_type   diff;
      byte_type   addend;
      logic [8:0] sum;
      cin = beat.flags_in[FLAG_C];
      r.result = '0;
      r.negative = 1'b0;
      r.zero_flag = 1'b0;
      r.carry_out = cin;
      r.overflow_out = beat.flags_in[FLAG_V];
      nz_from_result = 1'b1;
      case (beat.command)
         CMD_LOAD: r.result = beat.operand;
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            if (beat.command == CMD_CMP) reg_val = beat.accumulator;
            else if (beat.command == CMD_CPX) reg_val = beat.x_value;
            else reg_val = beat.y_value;
            diff = reg_val - beat.operand;
            r.result = beat.operand;
            r.negative = diff[7];
            r.zero_flag = (reg_val == beat.operand);
            r.carry_out = (reg_val >= beat.operand);
            nz_from_result = 1'b0;
         end
         CMD_AND: r.result = beat.accumulator & beat.operand;
         CMD_ORA: r.result = beat.accumulator | beat.operand;
         CMD_EOR: r.result = beat.accumulator ^ beat.operand;
         CMD_BIT: begin
            r.result = beat.operand;
            r.negative = beat.operand[7];
            r.overflow_out = beat.operand[6];
            r.zero_flag = ((beat.accumulator & beat.operand) == '0);
            nz_from_result = 1'b0;
         end
         CMD_ASL: begin
            r.carry_out = beat.operand[7];
            r.result = {beat.operand[6:0], 1'b0};
         end
         CMD_LSR: begin
            r.carry_out = beat.operand[0];
            r.result = {1'b0, beat.operand[7:1]};
         end
         CMD_ROL: begin
            r.carry_out = beat.operand[7];
            r.result = {beat.operand[6:0], cin};
         end
         CMD_ROR: begin
            r.carry_out = beat.operand[0];
            r.result = {cin, beat.operand[7:1]};
         end
         CMD_ADC, CMD_SBC: begin
            addend = (beat.command == CMD_SBC) ? ~beat.operand : beat.operand;
            sum = {1'b0, beat.accumulator} + {1'b0, addend} + {8'd0, cin};
            r.result = sum[7:0];
            r.carry_out = sum[8];
            r.overflow_out = ~(beat.accumulator[7] ^ addend[7])
                             & (beat.accumulator[7] ^ sum[7]);
         end
         CMD_DEC: r.result = beat.operand - 8'd1;
         default: r.result = beat.operand + 8'd1;
      endcase
      if (nz_from_result) begin
         r.negative = r.result[7];
         r.zero_flag = (r.result == '0);
      end
      return r;
   endfunction

   function automatic byte_type corner_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_beat(cmd_type cmd, byte_type m, byte_type a, byte_type x,
                             byte_type y, logic [3:0] fl);
      req_type beat;
      beat.command = cmd;
      beat.operand = m;
      beat.accumulator = a;
      beat.x_value = x;
      beat.y_value = y;
      beat.flags_in = fl;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   task automatic queue_random(int unsigned count);
      cmd_type  cmd;
      byte_type m;
      byte_type a;
      byte_type x;
      byte_type y;
      repeat (count) begin
         cmd = cmd_type'($urandom_range(15));
         m = corner_byte();
         a = corner_byte();
         x = corner_byte();
         y = corner_byte();
         // equal operands make the compare and zero cases common
         if ($urandom_range(3) == 0) begin
            a = m;
            x = m;
            y = m;
         end
         queue_beat(cmd, m, a, x, y, 4'($urandom_range(15)));
      end
   endtask

   task automatic wait_drained();
      wait (pending_beats.size() == 0 && results_checked == beats_queued);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(alu_outcome(beat_on_bus));
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_bus = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_command <= beat_on_bus.command;
               req_operand <= beat_on_bus.operand;
               req_accumulator <= beat_on_bus.accumulator;
               req_x_value <= beat_on_bus.x_value;
               req_y_value <= beat_on_bus.y_value;
               req_flags_in <= beat_on_bus.flags_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("unexpected beat: result %h N%b Z%b C%b V%b", rsp_result,
                           rsp_negative, rsp_zero_flag, rsp_carry_out, rsp_overflow_out);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_result !== want.result || rsp_negative !== want.negative ||
                   rsp_zero_flag !== want.zero_flag || rsp_carry_out !== want.carry_out ||
                   rsp_overflow_out !== want.overflow_out) begin
                  if (fail_count < REPORT_MAX)
                     $display("mismatch: expected %h N%b Z%b C%b V%b, got %h N%b Z%b C%b V%b",
                              want.result, want.negative, want.zero_flag, want.carry_out,
                              want.overflow_out, rsp_result, rsp_negative, rsp_zero_flag,
                              rsp_carry_out, rsp_overflow_out);
                  fail_count++;
               end
            end
         end
         if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            stall_run = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_beat(CMD_LOAD, 8'h00, 8'h12, 8'h00, 8'h00, 4'hf);
      queue_beat(CMD_LOAD, 8'h80, 8'h00, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_CMP,  8'h40, 8'h40, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_CMP,  8'h20, 8'h10, 8'h00, 8'h00, 4'hf);
      queue_beat(CMD_CPX,  8'h00, 8'h00, 8'hff, 8'h00, 4'h4);
      queue_beat(CMD_CPY,  8'hff, 8'h00, 8'h00, 8'h00, 4'h1);
      queue_beat(CMD_AND,  8'h0f, 8'hf0, 8'h00, 8'h00, 4'h5);
      queue_beat(CMD_AND,  8'h80, 8'hff, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_ORA,  8'h00, 8'h00, 8'h00, 8'h00, 4'ha);
      queue_beat(CMD_EOR,  8'hff, 8'hff, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_EOR,  8'h55, 8'haa, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_BIT,  8'hc0, 8'h0f, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_BIT,  8'h3f, 8'hff, 8'h00, 8'h00, 4'hf);
      queue_beat(CMD_ASL,  8'h80, 8'h00, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_LSR,  8'h01, 8'h00, 8'h00, 8'h00, 4'h8);
      queue_beat(CMD_ROL,  8'h80, 8'h00, 8'h00, 8'h00, 4'h1);
      queue_beat(CMD_ROR,  8'h01, 8'h00, 8'h00, 8'h00, 4'h1);
      queue_beat(CMD_ROR,  8'h00, 8'h00, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_ADC,  8'h01, 8'h7f, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_ADC,  8'h01, 8'hff, 8'h00, 8'h00, 4'h1);
      queue_beat(CMD_SBC,  8'h01, 8'h80, 8'h00, 8'h00, 4'h1);
      queue_beat(CMD_SBC,  8'h00, 8'h00, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_DEC,  8'h00, 8'h00, 8'h00, 8'h00, 4'h0);
      queue_beat(CMD_INC,  8'hff, 8'h00, 8'h00, 8'h00, 4'hf);
      queue_beat(CMD_INC,  8'h7f, 8'h00, 8'h00, 8'h00, 4'h0);
      wait_drained();

      send_idle_pct = 33;
      recv_idle_pct = 53;
      queue_random(333);
      wait_drained();

      send_idle_pct = 53;
      recv_idle_pct = 33;
      queue_random(333);
      wait_drained();

      // long hold-off on the result side while beats keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
      queue_random(334);
      wait_drained();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
